// ===== hw/rtl/bfth_pkg.sv =====
// Shared constants, types and state encoding for the two-hash Bloom filter.
package bfth_pkg;

  localparam int unsigned HASH_W     = 32;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned FB_W       = 23;
  localparam int unsigned HC_W       = 2;
  localparam int unsigned CNT_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 23;
  localparam int unsigned ROW_BITS   = 32;
  localparam int unsigned ROW_BIT_W  = 5;
  localparam int unsigned STEP_W     = 5;

  localparam int unsigned FILTER_DEPTH_DEF = 4194304;

  localparam logic [FB_W-1:0] FILTER_BITS_RST = FB_W'(2500000);
  localparam logic [HC_W-1:0] HASH_COUNT_RST  = HC_W'(2);

  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_COUNT  = 1'b1;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_MODIFY,
    ST_RESP
  } state_e;

endpackage

// ===== hw/rtl/bfth_hash.sv =====
// Shift-add-xor and sdbm hash accumulators, one key byte per item.
module bfth_hash (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [bfth_pkg::BYTE_W-1:0]   byte_i,
  input  logic                          last_i,
  output logic [bfth_pkg::HASH_W-1:0]   sax_o,
  output logic [bfth_pkg::HASH_W-1:0]   sdbm_o
);
  import bfth_pkg::*;

  logic [HASH_W-1:0] sax_q, sdbm_q;
  logic [HASH_W-1:0] sax_d, sdbm_d;
  logic [HASH_W-1:0] c_ext;

  assign c_ext = HASH_W'(byte_i);

  always_comb begin
    if (byte_i == '0) begin
      sax_o  = sax_q;
      sdbm_o = sdbm_q;
    end else begin
      sax_o  = sax_q ^ ((sax_q << 5) + (sax_q >> 2) + c_ext);
      sdbm_o = c_ext + (sdbm_q << 6) + (sdbm_q << 16) - sdbm_q;
    end
  end

  always_comb begin
    sax_d  = sax_q;
    sdbm_d = sdbm_q;
    if (en_i) begin
      sax_d  = last_i ? '0 : sax_o;
      sdbm_d = last_i ? '0 : sdbm_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sax_q  <= '0;
      sdbm_q <= '0;
    end else begin
      sax_q  <= sax_d;
      sdbm_q <= sdbm_d;
    end
  end

endmodule

// ===== hw/rtl/bfth_mod.sv =====
// Restoring modulo unit: 32-bit hash mod 23-bit modulus, one bit per cycle.
module bfth_mod (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bfth_pkg::HASH_W-1:0] dividend_i,
  input  logic [bfth_pkg::FB_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [bfth_pkg::FB_W-1:0]   rem_o
);
  import bfth_pkg::*;

  localparam logic [STEP_W-1:0] LastStep = STEP_W'(HASH_W - 1);

  logic              busy_q;
  logic [STEP_W-1:0] cnt_q;
  logic [HASH_W-1:0] quo_q;
  logic [FB_W-1:0]   rem_q, rem_d;
  logic [FB_W-1:0]   div_q;
  logic [FB_W:0]     trial;

  assign trial = {rem_q, quo_q[HASH_W-1]};

  always_comb begin
    if (trial >= {1'b0, div_q}) begin
      rem_d = FB_W'(trial - {1'b0, div_q});
    end else begin
      rem_d = trial[FB_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_q << 1;
      rem_q <= rem_d;
    end
  end

  assign done_o = !busy_q;
  assign rem_o  = rem_q;

endmodule

// ===== hw/rtl/bloom_filter_two_hash.sv =====
// Top level of the two-hash Bloom filter: control, filter memory and channels.
// Non-last key bytes are taken one per cycle; a last byte runs the modulo units, then
// one read and one write-back or test per hash. in_ready returns when an add's writes
// are done; a check's result and in_ready come together once its tests are done,
// later while the previous result still waits. After reset the filter memory is cleared
// one 32-bit row per cycle, ceil(FILTER_DEPTH/32) rows, before the first item is taken.
module bloom_filter_two_hash #(
  parameter int unsigned FILTER_DEPTH = bfth_pkg::FILTER_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            op_i,
  input  logic [bfth_pkg::BYTE_W-1:0]     key_byte_i,
  input  logic                            last_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            present_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bfth_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bfth_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bfth_pkg::*;

  localparam int unsigned ROWS   = (FILTER_DEPTH + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_AW-1:0] LastRow = ROW_AW'(ROWS - 1);

  state_e state_q, state_d;

  logic [FB_W-1:0]   filter_bits_q;
  logic [HC_W-1:0]   hash_count_q;
  logic              op_q;
  logic [CNT_W-1:0]  n_q, n_d;
  logic              k_q, k_d;
  logic              all_set_q, all_set_d;
  logic [ROW_AW-1:0] clr_q, clr_d;
  logic [FB_W-1:0]   m_q, m_d;
  logic              out_valid_q, out_valid_d;
  logic              present_q;

  logic              in_acc, key_end, load_out;
  logic [HASH_W-1:0] sax_h, sdbm_h;
  logic              mod_done, mod1_done;
  logic [FB_W-1:0]   rem0, rem1, pos;
  logic [ROW_AW-1:0] row;

  logic [ROW_BITS-1:0] mem_q [ROWS];
  logic [ROW_BITS-1:0] rd_data_q;
  logic                mem_re, mem_we;
  logic [ROW_AW-1:0]   mem_waddr;
  logic [ROW_BITS-1:0] mem_wdata;

  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign key_end     = in_acc && last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filter_bits_q <= FILTER_BITS_RST;
      hash_count_q  <= HASH_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FILTER_BITS: filter_bits_q <= cfg_data_i;
        CFG_HASH_COUNT:  hash_count_q  <= cfg_data_i[HC_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (filter_bits_q == '0) begin
      m_d = FB_W'(1);
    end else if (HASH_W'(filter_bits_q) > HASH_W'(FILTER_DEPTH)) begin
      m_d = FB_W'(FILTER_DEPTH);
    end else begin
      m_d = filter_bits_q;
    end
    if (hash_count_q == '0) begin
      n_d = CNT_W'(0);
    end else if (hash_count_q == HC_W'(1)) begin
      n_d = CNT_W'(1);
    end else begin
      n_d = CNT_W'(2);
    end
  end

  bfth_hash u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (in_acc),
    .byte_i (key_byte_i),
    .last_i (last_byte_i),
    .sax_o  (sax_h),
    .sdbm_o (sdbm_h)
  );

  bfth_mod u_mod0 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (key_end),
    .dividend_i (sax_h),
    .divisor_i  (m_d),
    .done_o     (mod_done),
    .rem_o      (rem0)
  );

  bfth_mod u_mod1 (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (key_end),
    .dividend_i (sdbm_h),
    .divisor_i  (m_d),
    .done_o     (mod1_done),
    .rem_o      (rem1)
  );

  assign pos = k_q ? rem1 : rem0;
  assign row = ROW_AW'(pos >> ROW_BIT_W);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == LastRow) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (key_end) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (mod_done && mod1_done) begin
          if (n_q != '0) begin
            state_d = ST_READ;
          end else begin
            state_d = (op_q == OP_CHECK) ? ST_RESP : ST_IDLE;
          end
        end
      end
      ST_READ: begin
        state_d = ST_MODIFY;
      end
      ST_MODIFY: begin
        if (!k_q && n_q == CNT_W'(2)) begin
          state_d = ST_READ;
        end else begin
          state_d = (op_q == OP_CHECK) ? ST_RESP : ST_IDLE;
        end
      end
      ST_RESP: begin
        if (load_out) state_d = ST_IDLE;
      end
    endcase
  end

  // outputs and datapath control
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = row;
    mem_wdata  = rd_data_q | (ROW_BITS'(1) << pos[ROW_BIT_W-1:0]);
    load_out   = 1'b0;
    clr_d      = clr_q;
    k_d        = k_q;
    all_set_d  = all_set_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && last_byte_i) begin
          all_set_d = 1'b1;
          k_d       = 1'b0;
        end
      end
      ST_DIV: ;
      ST_READ: begin
        mem_re = 1'b1;
      end
      ST_MODIFY: begin
        if (op_q == OP_ADD) begin
          mem_we = 1'b1;
        end else begin
          all_set_d = all_set_q & rd_data_q[pos[ROW_BIT_W-1:0]];
        end
        if (!k_q && n_q == CNT_W'(2)) k_d = 1'b1;
      end
      ST_RESP: begin
        load_out = !out_valid_q || out_ready_i;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_ready_i) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      k_q         <= 1'b0;
      all_set_q   <= 1'b1;
      out_valid_q <= 1'b0;
      op_q        <= OP_ADD;
      n_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      k_q         <= k_d;
      all_set_q   <= all_set_d;
      out_valid_q <= out_valid_d;
      if (key_end) begin
        op_q <= op_i;
        n_q  <= n_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_end) m_q <= m_d;
    if (load_out) present_q <= all_set_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_q <= mem_q[row];
  end

  assign out_valid_o = out_valid_q;
  assign present_o   = present_q;

  a_modify_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MODIFY |-> $past(state_q) == ST_READ)
    else $error("modify without a preceding read");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> pos < m_q)
    else $error("bit position not below modulus");

  a_second_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ && k_q) |-> n_q == CNT_W'(2))
    else $error("second hash used with fewer than two hashes");

  a_resp_check_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RESP |-> op_q == OP_CHECK)
    else $error("result for an add item");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLEAR || (state_q == ST_MODIFY && op_q == OP_ADD)))
    else $error("filter write outside clear or add");

endmodule
